// ===== src/rsp_pkg.sv =====
// ----------------------------------------------------------------------------
// rsp_pkg
// Shared types for the price sort chain: one record word as held in a cell.
// ----------------------------------------------------------------------------
package rsp_pkg;

    localparam int PRICE_W = 32;
    localparam int CODE_W  = 64;
    // arrival index within a set, wide enough for a 64-record store
    localparam int SEQ_W   = 7;

    typedef struct packed {
        logic                      valid;
        logic signed [PRICE_W-1:0] price;
        logic [CODE_W-1:0]         code;
        logic [SEQ_W-1:0]          seq;
    } rec_t;

endpackage

// ===== src/rsp_cell.sv =====
// ----------------------------------------------------------------------------
// rsp_cell
// One insertion cell: keeps the smaller of its stored record and the incoming
// one, hands the other to the next cell. Shifts toward the head while draining.
// ----------------------------------------------------------------------------
module rsp_cell (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        shift,
    input  rsp_pkg::rec_t rec_in,
    input  rsp_pkg::rec_t shift_in,
    output rsp_pkg::rec_t stored,
    output rsp_pkg::rec_t pass_out
);
    import rsp_pkg::*;

    rec_t stored_reg, stored_next;
    rec_t pass_reg, pass_next;

    always_comb
    begin
        stored_next = stored_reg;
        pass_next   = '0;
        if (shift)
        begin
            stored_next = shift_in;
        end
        else if (rec_in.valid)
        begin
            if (!stored_reg.valid)
            begin
                stored_next = rec_in;
            end
            else if (($signed(stored_reg.price) > $signed(rec_in.price))
                     || ((stored_reg.price == rec_in.price)
                         && (stored_reg.seq > rec_in.seq)))
            begin
                // new word sorts first: take it, push the old one on
                stored_next = rec_in;
                pass_next   = stored_reg;
            end
            else
            begin
                // equal prices order by arrival index, which keeps arrival order
                pass_next = rec_in;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stored_reg <= '0;
            pass_reg   <= '0;
        end
        else
        begin
            stored_reg <= stored_next;
            pass_reg   <= pass_next;
        end
    end

    assign stored   = stored_reg;
    assign pass_out = pass_reg;

endmodule

// ===== src/record_sort_by_price.sv =====
// ----------------------------------------------------------------------------
// record_sort_by_price
// Stable ascending sort of price/code records in a systolic insertion chain.
// ----------------------------------------------------------------------------
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  in      | in_valid in_ready price item_code last_in | sink
//  out     | out_valid out_ready sorted_price          | source
//          |   sorted_code last_out overflow           |
//
// Loading takes one word per cycle while in_ready is high; words beyond DEPTH
// are dropped and flagged. After the closing word the chain settles as words
// travel down the cell row; cell 0 then emits one sorted word per cycle.
// in_ready is low from the closing word until the last sorted word is taken.
// Output words come straight from cell 0 registers and hold while stalled.
// Reset empties every cell and clears the count and the drop flag.
// ----------------------------------------------------------------------------
module record_sort_by_price #(
    parameter int DEPTH = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [31:0] price,
    input  logic [63:0]        item_code,
    input  logic               last_in,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] sorted_price,
    output logic [63:0]        sorted_code,
    output logic               last_out,
    output logic               overflow
);
    import rsp_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);

    typedef enum logic [2:0] {
        ST_LOAD   = 3'b001,
        ST_SETTLE = 3'b010,
        ST_EMIT   = 3'b100
    } state_t;

    state_t state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] settle_reg, settle_next;
    logic dropped_reg, dropped_next;

    rec_t cell_in    [DEPTH];
    rec_t cell_pass  [DEPTH];
    rec_t cell_store [DEPTH];
    rec_t shift_src  [DEPTH];
    rec_t head_in;

    logic in_acc, out_acc, full;

    assign in_ready = (state_reg == ST_LOAD);
    assign in_acc   = in_valid && in_ready;
    assign full     = (count_reg == CNT_W'(DEPTH));
    assign out_valid = (state_reg == ST_EMIT) && cell_store[0].valid;
    assign out_acc  = out_valid && out_ready;

    always_comb
    begin
        head_in       = '0;
        head_in.valid = in_acc && !full;
        head_in.price = price;
        head_in.code  = item_code;
        // tag with arrival index so equal prices keep their order
        head_in.seq   = SEQ_W'(count_reg);
    end

    genvar i;
    generate
        for (i = 0; i < DEPTH; i++)
        begin : g_cell
            if (i == 0)
            begin : g_head
                assign cell_in[i] = head_in;
            end
            else
            begin : g_body
                assign cell_in[i] = cell_pass[i-1];
            end
            if (i == DEPTH - 1)
            begin : g_tail
                assign shift_src[i] = '0;
            end
            else
            begin : g_mid
                assign shift_src[i] = cell_store[i+1];
            end
            rsp_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .shift    (out_acc),
                .rec_in   (cell_in[i]),
                .shift_in (shift_src[i]),
                .stored   (cell_store[i]),
                .pass_out (cell_pass[i])
            );
        end
    endgenerate

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        settle_next  = settle_reg;
        dropped_next = dropped_reg;
        case (state_reg)
            ST_LOAD:
            begin
                if (in_acc)
                begin
                    if (full)
                    begin
                        dropped_next = 1'b1;
                    end
                    else
                    begin
                        count_next = count_reg + CNT_W'(1);
                    end
                    if (last_in)
                    begin
                        settle_next = CNT_W'(DEPTH);
                        state_next  = ST_SETTLE;
                    end
                end
            end
            ST_SETTLE:
            begin
                if (settle_reg == '0)
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    settle_next = settle_reg - CNT_W'(1);
                end
            end
            ST_EMIT:
            begin
                if (out_acc && last_out)
                begin
                    count_next   = '0;
                    dropped_next = 1'b0;
                    state_next   = ST_LOAD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_LOAD;
            count_reg   <= '0;
            settle_reg  <= '0;
            dropped_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            settle_reg  <= settle_next;
            dropped_reg <= dropped_next;
        end
    end

    assign sorted_price = cell_store[0].price;
    assign sorted_code  = cell_store[0].code;
    // last word when nothing stands behind the head cell
    assign last_out     = !cell_store[1].valid;
    assign overflow     = dropped_reg;

endmodule

// ===== verif/record_sort_by_price_tb.sv =====
// ----------------------------------------------------------------------------
// record_sort_by_price_tb
// Self-checking bench for the price sort chain. Sets of records are loaded
// through the input channel and closed by last_in. A local stable sort
// predicts the order in which each set comes back. Both channels idle in
// random bursts, and the run includes a full store and a set that overflows it.
// ----------------------------------------------------------------------------
module record_sort_by_price_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import rsp_pkg::*;

    localparam int DEPTH       = 64;
    localparam int ITEM_TARGET = 270;
    localparam int CALM_TAIL   = 40;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct {
        logic signed [PRICE_W-1:0] price;
        logic [CODE_W-1:0]         code;
        logic                      last;
    } record_word_t;

    typedef struct {
        logic signed [PRICE_W-1:0] price;
        logic [CODE_W-1:0]         code;
        logic                      last;
        logic                      ovf;
    } sorted_word_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                      in_valid = 1'b0;
    logic                      in_ready;
    logic signed [PRICE_W-1:0] price = '0;
    logic [CODE_W-1:0]         item_code = '0;
    logic                      last_in = 1'b0;
    logic                      out_valid;
    logic                      out_ready = 1'b0;
    logic signed [PRICE_W-1:0] sorted_price;
    logic [CODE_W-1:0]         sorted_code;
    logic                      last_out;
    logic                      overflow;

    record_word_t pending_words[$];
    sorted_word_t sorted_due[$];

    // set being collected by the predictor
    logic signed [PRICE_W-1:0] held_price[$];
    logic [CODE_W-1:0]         held_code[$];
    logic                      held_dropped = 1'b0;

    int errors = 0;
    int sets_closed = 0;
    int overflow_sets = 0;
    int words_checked = 0;
    int items_queued = 0;
    int cycles = 0;
    int send_gap = 0;
    int take_stall = 0;
    sorted_word_t got_due;
    record_word_t next_word;

    record_sort_by_price #(.DEPTH(DEPTH)) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .price        (price),
        .item_code    (item_code),
        .last_in      (last_in),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .sorted_price (sorted_price),
        .sorted_code  (sorted_code),
        .last_out     (last_out),
        .overflow     (overflow)
    );

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d words still due", cycles,
                     sorted_due.size());
            $display("FAILURE");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("[%0t] mismatch on %s: got %h, expected %h", $realtime, what,
                 got, want);
        errors++;
    endtask

    // Take one accepted record into the set; on the closing record, sort the
    // set stably by signed price and queue the words that must come back.
    task automatic collect_record(input logic signed [PRICE_W-1:0] p,
                                  input logic [CODE_W-1:0] c, input logic last);
        int n;
        int j;
        logic signed [PRICE_W-1:0] kp;
        logic [CODE_W-1:0]         kc;
        sorted_word_t w;
        if (held_price.size() < DEPTH)
        begin
            held_price.push_back(p);
            held_code.push_back(c);
        end
        else
        begin
            held_dropped = 1'b1;
        end
        if (!last)
            return;
        n = held_price.size();
        // insertion sort; strict compare keeps equal prices in arrival order
        for (int i = 1; i < n; i++)
        begin
            kp = held_price[i];
            kc = held_code[i];
            j = i - 1;
            while (j >= 0 && held_price[j] > kp)
            begin
                held_price[j + 1] = held_price[j];
                held_code[j + 1] = held_code[j];
                j--;
            end
            held_price[j + 1] = kp;
            held_code[j + 1] = kc;
        end
        for (int i = 0; i < n; i++)
        begin
            w.price = held_price[i];
            w.code = held_code[i];
            w.last = (i == n - 1);
            w.ovf = held_dropped;
            sorted_due.push_back(w);
        end
        sets_closed++;
        if (held_dropped)
            overflow_sets++;
        held_price.delete();
        held_code.delete();
        held_dropped = 1'b0;
    endtask

    task automatic queue_record(input logic signed [PRICE_W-1:0] p,
                                input logic [CODE_W-1:0] c, input logic last);
        record_word_t w;
        w.price = p;
        w.code = c;
        w.last = last;
        pending_words.push_back(w);
        items_queued++;
    endtask

    function automatic logic [CODE_W-1:0] rand_code();
        return {$urandom, $urandom};
    endfunction

    function automatic logic signed [PRICE_W-1:0] rand_price(input int mode);
        case (mode)
            0: return $signed($urandom);
            1: return $signed($urandom_range(0, 6)) - 3;         // many ties
            2: return 32'sh7fffffff - $signed($urandom_range(0, 3));
            3: return 32'sh80000000 + $signed($urandom_range(0, 3));
            default: return $signed($urandom_range(0, 32'h0003_0000)) - 32'sh0001_8000;
        endcase
    endfunction

    task automatic queue_random_set(input int n);
        int mode;
        mode = $urandom_range(0, 5);
        for (int i = 0; i < n; i++)
        begin
            // mixed sets draw a fresh price style per record
            queue_record(rand_price(mode == 5 ? $urandom_range(0, 4) : mode),
                         rand_code(), i == n - 1);
        end
    endtask

    // Input side: hold the word until taken, then advance or idle.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            send_gap <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
                collect_record(price, item_code, last_in);
            if (!in_valid || in_ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap <= send_gap - 1;
                    in_valid <= 1'b0;
                end
                else if (pending_words.size() > CALM_TAIL && $urandom_range(0, 7) == 0)
                begin
                    send_gap <= $urandom_range(1, 19) - 1;
                    in_valid <= 1'b0;
                end
                else if (pending_words.size() > 0)
                begin
                    next_word = pending_words.pop_front();
                    price <= next_word.price;
                    item_code <= next_word.code;
                    last_in <= next_word.last;
                    in_valid <= 1'b1;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Output side: check each taken word, stall in bursts.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            take_stall <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (sorted_due.size() == 0)
                begin
                    report_mismatch("unexpected word (price)", 64'(sorted_price), '0);
                end
                else
                begin
                    got_due = sorted_due.pop_front();
                    words_checked++;
                    if (sorted_price !== got_due.price)
                        report_mismatch("sorted_price", 64'(sorted_price),
                                        64'(got_due.price));
                    if (sorted_code !== got_due.code)
                        report_mismatch("sorted_code", sorted_code, got_due.code);
                    if (last_out !== got_due.last)
                        report_mismatch("last_out", 64'(last_out), 64'(got_due.last));
                    if (overflow !== got_due.ovf)
                        report_mismatch("overflow", 64'(overflow), 64'(got_due.ovf));
                end
            end
            if (take_stall > 0)
            begin
                take_stall <= take_stall - 1;
                out_ready <= 1'b0;
            end
            else if (pending_words.size() > CALM_TAIL && $urandom_range(0, 7) == 0)
            begin
                take_stall <= $urandom_range(1, 19) - 1;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    initial
    begin
        bit big_full_done;
        bit big_over_done;
        big_full_done = 1'b0;
        big_over_done = 1'b0;

        // single records at the price extremes
        queue_record(32'sh7fffffff, '1, 1'b1);
        queue_record(32'sh80000000, '0, 1'b1);
        // mixed signs, ties and extremes in one set
        queue_record(32'sh00000000, 64'h4142_4344_4546_4748, 1'b0);
        queue_record(32'sh7fffffff, 64'h0000_0000_0000_0001, 1'b0);
        queue_record(32'sh80000000, 64'h8000_0000_0000_0000, 1'b0);
        queue_record(-32'sd1,       64'hffff_ffff_ffff_fffe, 1'b0);
        queue_record(32'sh00000000, 64'h5a5a_5a5a_5a5a_5a5a, 1'b0);
        queue_record(32'sd1,        64'ha5a5_a5a5_a5a5_a5a5, 1'b0);
        queue_record(32'sh00000000, 64'h0123_4567_89ab_cdef, 1'b1);
        // strictly descending set, every pair swaps
        for (int i = 0; i < 5; i++)
            queue_record(32'sh0005_0000 - i * 32'sh0001_0000, 64'(i), i == 4);
        // two equal prices must keep arrival order
        queue_record(32'sh0001_8000, 64'hdead_beef_0000_0001, 1'b0);
        queue_record(32'sh0001_8000, 64'hdead_beef_0000_0002, 1'b1);

        // random sets; one that fills the store exactly and one that loses
        // records including its closing one
        while (items_queued < ITEM_TARGET)
        begin
            if (!big_full_done && items_queued > 60)
            begin
                queue_random_set(DEPTH);
                big_full_done = 1'b1;
            end
            else if (!big_over_done && items_queued > 150)
            begin
                queue_random_set(DEPTH + 2);
                big_over_done = 1'b1;
            end
            else
            begin
                queue_random_set($urandom_range(1, 12));
            end
        end

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_words.size() > 0 || in_valid)
            @(posedge clk);
        while (sorted_due.size() > 0)
            @(posedge clk);
        repeat (2 * DEPTH + 8) @(posedge clk);

        $display("loaded %0d records in %0d sets (%0d overflowed), checked %0d sorted words",
                 items_queued, sets_closed, overflow_sets, words_checked);
        $display("random idling on both channels, quiet for the last %0d records",
                 CALM_TAIL);
        if (errors == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("%0d mismatches", errors);
            $display("FAILURE");
        end
        $finish;
    end

endmodule
